// ----- hdl/servo_bank_slew_emulator_assert.svh -----
// ----------------------------------------------------------------------------
// Servo bank slew emulator assertion macros
// Concurrent assertion wrappers on clk with rst_n as the disable condition.
// ----------------------------------------------------------------------------
`ifndef SERVO_BANK_SLEW_EMULATOR_ASSERT_SVH
`define SERVO_BANK_SLEW_EMULATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, ante, cons)

`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- hdl/sbse_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo bank slew emulator package
// Shared sizes, opcodes, payload structs and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package sbse_pkg;

  localparam int SERVOS       = 6;
  localparam int SINE_ENTRIES = 1024;
  localparam int IDX_W        = (SERVOS > 1) ? $clog2(SERVOS) : 1;
  localparam int SINE_W       = $clog2(SINE_ENTRIES);

  typedef enum logic [1:0] {
    OP_GOAL  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_PING  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  motor_id;
    logic [7:0]  reg_address;
    logic [7:0]  read_length;
    logic [15:0] value;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [2:0] reply_id;
    logic       has_position;
    logic [9:0] position;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic phase;
    logic lookup;
    logic mul;
    logic apply;
    logic write_speed;
    logic emit;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic id_ok;
    logic pos_req;
    logic speed_req;
    op_t  op;
  } sts_t;

endpackage

// ----- hdl/sbse_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo bank slew emulator controller
// Sequences decode, motor update and reply for one instruction at a time.
// ----------------------------------------------------------------------------
module sbse_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  sbse_pkg::sts_t sts,
  output logic          busy,
  output sbse_pkg::ctl_t ctl
);
  import sbse_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_DECODE = 7'b0000010,
    ST_PHASE  = 7'b0000100,
    ST_LOOKUP = 7'b0001000,
    ST_MUL    = 7'b0010000,
    ST_APPLY  = 7'b0100000,
    ST_REPLY  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      ST_IDLE: begin
        ctl.load = start;
        if (start) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        if (!sts.id_ok) begin
          state_nxt = ST_IDLE;
        end else begin
          unique case (sts.op)
            OP_GOAL: state_nxt = ST_PHASE;
            OP_READ: state_nxt = sts.pos_req ? ST_PHASE : ST_IDLE;
            OP_WRITE: begin
              ctl.write_speed = sts.speed_req;
              state_nxt       = sts.speed_req ? ST_REPLY : ST_IDLE;
            end
            OP_PING: state_nxt = ST_REPLY;
          endcase
        end
      end
      ST_PHASE: begin
        ctl.phase = 1'b1;
        state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        ctl.lookup = 1'b1;
        state_nxt  = ST_MUL;
      end
      ST_MUL: begin
        ctl.mul   = 1'b1;
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        ctl.apply = 1'b1;
        // goal entries are silent, reads go on to reply
        state_nxt = (sts.op == OP_READ) ? ST_REPLY : ST_IDLE;
      end
      ST_REPLY: begin
        ctl.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ----- hdl/sbse_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo bank slew emulator datapath
// Per-servo state, sine sweep lookup, slew step arithmetic and reply register.
// ----------------------------------------------------------------------------
module sbse_datapath (
  input  logic           clk,
  input  logic           rst_n,
  input  sbse_pkg::ctl_t ctl,
  input  sbse_pkg::in_t  in_data,
  output sbse_pkg::sts_t sts,
  output sbse_pkg::out_t out_data,
  output logic           out_valid
);
  import sbse_pkg::*;

  localparam logic [31:0]        PHASE_PER_MS   = 32'd375961;
  localparam logic [63:0]        PHASE_PER_ID   = 64'd715827883;
  localparam logic signed [27:0] MID_Q16        = 28'sd33521664;
  localparam logic signed [27:0] SWING          = 28'sd220;
  localparam logic [9:0]         POS_MAX        = 10'd1023;
  localparam logic [25:0]        POS_MAX_Q16    = {10'd1023, 16'd0};
  localparam logic [39:0]        RATE_PER_SPEED = 40'd9754128;
  localparam logic [32:0]        RATE_MAX       = 33'd8523877995;
  localparam logic [15:0]        SPEED_RESET    = 16'd315;
  localparam logic [7:0]         ADDR_POSITION  = 8'd36;
  localparam logic [7:0]         ADDR_SPEED     = 8'd32;
  localparam logic [7:0]         READ_LEN       = 8'd2;
  localparam int                 GAP_BITS       = 20;

  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;

  typedef logic signed [17:0] sine_tab_t [SINE_ENTRIES];
  typedef logic [31:0]        id_phase_t [SERVOS];

  // sin(2*pi*k/N) in Q16 by a Taylor series on a Q30 angle
  function automatic sine_tab_t build_sine();
    sine_tab_t   tab;
    logic [63:0] th;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    logic        neg;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      th  = (64'(k) * TWO_PI_Q30) / SINE_ENTRIES;
      neg = 1'b0;
      if (th >= PI_Q30) begin
        neg = 1'b1;
        th  = th - PI_Q30;
      end
      if (th > HALF_PI_Q30) th = PI_Q30 - th;
      x2   = (th * th) >> 30;
      term = th;
      sum  = th;
      term = ((term * x2) >> 30) / 6;   sum = sum - term;
      term = ((term * x2) >> 30) / 20;  sum = sum + term;
      term = ((term * x2) >> 30) / 42;  sum = sum - term;
      term = ((term * x2) >> 30) / 72;  sum = sum + term;
      term = ((term * x2) >> 30) / 110; sum = sum - term;
      term = ((term * x2) >> 30) / 156; sum = sum + term;
      r = (sum + 64'd8192) >> 14;
      tab[k] = neg ? -18'(r) : 18'(r);
    end
    return tab;
  endfunction

  function automatic id_phase_t build_id_phase();
    id_phase_t tab;
    for (int i = 0; i < SERVOS; i++) begin
      tab[i] = 32'((64'(i) + 64'd1) * PHASE_PER_ID);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();
  localparam id_phase_t ID_PHASE = build_id_phase();

  // captured instruction
  in_t              item_r;
  logic [IDX_W-1:0] idx_r;

  // per-servo state
  logic [25:0]       pos_r   [SERVOS];
  logic [9:0]        goal_r  [SERVOS];
  logic [15:0]       speed_r [SERVOS];
  logic [31:0]       last_r  [SERVOS];
  logic [SERVOS-1:0] mode_r;

  // update pipeline
  logic [31:0]        phase_r, phase_nxt;
  logic [31:0]        elapsed_r, elapsed_nxt;
  logic [39:0]        rate_prod_r, rate_prod_nxt;
  logic               speed_zero_r;
  logic signed [17:0] sine_r;
  logic [52:0]        step_prod_r, step_prod_nxt;
  logic               long_gap_r;
  logic [9:0]         idle_pos_r, idle_pos_nxt;
  logic [25:0]        step_r, step_nxt;
  out_t               out_r, out_nxt;
  logic               out_valid_r;

  logic [25:0]        cur_pos;
  logic [9:0]         cur_goal;
  logic [15:0]        cur_speed;
  logic [31:0]        cur_last;
  logic               cur_mode;
  logic [31:0]        now;
  logic [SINE_W-1:0]  sine_idx;
  logic [32:0]        rate;
  logic signed [27:0] raw;
  logic [27:0]        raw_rnd;
  logic [11:0]        raw_int;
  logic [36:0]        step_shift;
  logic [25:0]        goal_q;
  logic [25:0]        diff;
  logic [25:0]        move;
  logic [25:0]        new_pos;
  logic [9:0]         goal_nxt;
  logic [26:0]        rd_rnd;
  logic [9:0]         rd_pos;

  always_comb begin
    cur_pos   = pos_r[idx_r];
    cur_goal  = goal_r[idx_r];
    cur_speed = speed_r[idx_r];
    cur_last  = last_r[idx_r];
    cur_mode  = mode_r[idx_r];
    now       = item_r.now_ms;

    sts.id_ok     = (item_r.motor_id != 8'd0) && (item_r.motor_id <= 8'(SERVOS));
    sts.pos_req   = (item_r.reg_address == ADDR_POSITION) && (item_r.read_length == READ_LEN);
    sts.speed_req = (item_r.reg_address == ADDR_SPEED);
    sts.op        = op_t'(item_r.command);

    // sweep phase wraps as a 32-bit turn fraction
    phase_nxt     = now * PHASE_PER_MS + ID_PHASE[idx_r];
    elapsed_nxt   = (now >= cur_last) ? now - cur_last : 32'd0;
    rate_prod_nxt = 40'(cur_speed) * RATE_PER_SPEED;

    sine_idx = SINE_W'((64'(phase_r) * 64'(SINE_ENTRIES)) >> 32);

    if (speed_zero_r || (rate_prod_r > 40'(RATE_MAX))) rate = RATE_MAX;
    else                                               rate = rate_prod_r[32:0];
    step_prod_nxt = 53'(rate) * 53'(elapsed_r[GAP_BITS-1:0]);

    raw     = MID_Q16 + 28'(sine_r) * SWING;
    raw_rnd = (raw < 0) ? 28'd32768 : 28'(raw) + 28'd32768;
    raw_int = raw_rnd[27:16];
    idle_pos_nxt = (raw_int > 12'(POS_MAX)) ? POS_MAX : raw_int[9:0];

    step_shift = step_prod_r[52:16];
    step_nxt   = (long_gap_r || (step_shift > 37'(POS_MAX_Q16))) ? POS_MAX_Q16
                                                                  : step_shift[25:0];

    // move toward the goal by at most one step
    goal_q = {cur_goal, 16'd0};
    if (goal_q > cur_pos) begin
      diff = goal_q - cur_pos;
      move = (diff > step_r) ? cur_pos + step_r : goal_q;
    end else begin
      diff = cur_pos - goal_q;
      move = (diff > step_r) ? cur_pos - step_r : goal_q;
    end
    new_pos = cur_mode ? move : {idle_pos_r, 16'd0};

    goal_nxt = (item_r.value > 16'(POS_MAX)) ? POS_MAX : item_r.value[9:0];

    rd_rnd = 27'(cur_pos) + 27'd32768;
    rd_pos = (rd_rnd[26:16] > 11'(POS_MAX)) ? POS_MAX : rd_rnd[25:16];

    out_nxt.reply_id     = item_r.motor_id[2:0];
    out_nxt.has_position = (sts.op == OP_READ);
    out_nxt.position     = (sts.op == OP_READ) ? rd_pos : 10'd0;
  end

  // instruction capture and pipeline registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_r <= in_data;
      idx_r  <= IDX_W'(in_data.motor_id - 8'd1);
    end
    if (ctl.phase) begin
      phase_r      <= phase_nxt;
      elapsed_r    <= elapsed_nxt;
      rate_prod_r  <= rate_prod_nxt;
      speed_zero_r <= (cur_speed == 16'd0);
    end
    if (ctl.lookup) begin
      sine_r      <= SINE_TAB[sine_idx];
      step_prod_r <= step_prod_nxt;
      long_gap_r  <= |elapsed_r[31:GAP_BITS];
    end
    if (ctl.mul) begin
      idle_pos_r <= idle_pos_nxt;
      step_r     <= step_nxt;
    end
    if (ctl.emit) out_r <= out_nxt;
  end

  // servo state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SERVOS; i++) begin
        pos_r[i]   <= '0;
        goal_r[i]  <= '0;
        speed_r[i] <= SPEED_RESET;
        last_r[i]  <= '0;
      end
      mode_r <= '0;
    end else begin
      if (ctl.apply) begin
        pos_r[idx_r]  <= new_pos;
        last_r[idx_r] <= now;
        if (sts.op == OP_GOAL) begin
          goal_r[idx_r] <= goal_nxt;
          mode_r[idx_r] <= 1'b1;
        end
      end
      if (ctl.write_speed) speed_r[idx_r] <= item_r.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= ctl.emit;
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

endmodule

// ----- hdl/servo_bank_slew_emulator.sv -----
`timescale 1ns / 1ps
// A position read steps through decode, phase, sine lookup, multiply, apply and reply,
//   then strobes its registered reply; a speed write or ping goes from decode to reply;
//   a goal entry drops busy after apply. One instruction is taken at a time; the
//   controller walks phase, sine lookup, multiply and apply steps of the motor update.
// Results are strobed for one cycle and cannot be stalled by the receiver.
// Reset (synchronous, rst_n low) clears all servo state: speed 315, idle.
// ----------------------------------------------------------------------------
// Servo bank slew emulator
// Top level joining the instruction controller and the servo datapath.
// ----------------------------------------------------------------------------
`include "servo_bank_slew_emulator_assert.svh"

module servo_bank_slew_emulator (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  sbse_pkg::in_t  in_data,
  output logic           out_valid,
  output sbse_pkg::out_t out_data
);
  import sbse_pkg::*;

  ctl_t ctl;
  sts_t sts;

  sbse_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .ctl   (ctl)
  );

  sbse_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_data   (in_data),
    .sts       (sts),
    .out_data  (out_data),
    .out_valid (out_valid)
  );

  `ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)
  `ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `ASSERT_IMPLIES(a_empty_reply, out_valid && !out_data.has_position, out_data.position == 10'd0)
  `ASSERT_IMPLIES(a_apply_id, ctl.apply, sts.id_ok)

endmodule

// ----- dv/tb_servo_bank_slew_emulator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo bank slew emulator testbench
// Sends decoded bus instructions in random bursts, predicts each status reply
// from a fixed-point model of the servo bank, and checks every strobed reply.
// ----------------------------------------------------------------------------
module tb_servo_bank_slew_emulator;
  import sbse_pkg::*;

  localparam logic [7:0] ADDR_PRESENT_POS  = 8'd36;
  localparam logic [7:0] ADDR_MOVING_SPEED = 8'd32;
  localparam logic [7:0] POS_READ_LEN      = 8'd2;

  localparam longint unsigned PI_Q30           = 64'd3373259426;
  localparam longint unsigned HALF_PI_Q30      = 64'd1686629713;
  localparam longint unsigned TWO_PI_Q30       = 64'd6746518852;
  localparam longint unsigned PHASE_PER_MS     = 64'd375961;
  localparam longint unsigned PHASE_PER_ID     = 64'd715827883;
  localparam longint          MID_Q16          = 64'sd33521664;
  localparam longint          SWING            = 64'sd220;
  localparam int unsigned     POS_MAX          = 1023;
  localparam longint unsigned POS_MAX_Q16      = 64'd67043328;
  localparam longint unsigned RATE_PER_SPEED   = 64'd9754128;
  localparam longint unsigned RATE_MAX         = 64'd8523877995;
  localparam longint unsigned STEP_SAT_ELAPSED = 64'd1048576;
  localparam logic [15:0]     SPEED_RESET      = 16'd315;

  localparam int ITEM_TARGET  = 1650;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PRINT_CAP    = 40;

  class servo_reply_board;
    int          sine_q16 [SINE_ENTRIES];
    logic [25:0] position_q16 [SERVOS];
    logic [9:0]  goal [SERVOS];
    logic [15:0] speed [SERVOS];
    logic [31:0] last_ms [SERVOS];
    bit          slewing [SERVOS];
    out_t        replies_due [$];
    int          mismatches;
    int          served;
    int          replies_seen;
    int          position_replies;

    function new();
      for (int k = 0; k < SINE_ENTRIES; k++) sine_q16[k] = sine_point(k);
      for (int s = 0; s < SERVOS; s++) begin
        position_q16[s] = '0;
        goal[s]         = '0;
        speed[s]        = SPEED_RESET;
        last_ms[s]      = '0;
        slewing[s]      = 1'b0;
      end
      mismatches       = 0;
      served           = 0;
      replies_seen     = 0;
      position_replies = 0;
    endfunction

    // series to the x^13 term, angle folded into the first quadrant
    function int sine_point(int unsigned k);
      longint unsigned th, x2, term, total, r;
      bit neg;
      th  = (64'(k) * TWO_PI_Q30) / SINE_ENTRIES;
      neg = 1'b0;
      if (th >= PI_Q30) begin
        neg = 1'b1;
        th -= PI_Q30;
      end
      if (th > HALF_PI_Q30) th = PI_Q30 - th;
      x2    = (th * th) >> 30;
      term  = th;
      total = th;
      for (int n = 1; n <= 6; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) total -= term;
        else total += term;
      end
      r = (total + 64'd8192) >> 14;
      return neg ? -int'(r) : int'(r);
    endfunction

    function logic [25:0] idle_target(int unsigned id, logic [31:0] now);
      logic [31:0] phase;
      longint unsigned turn, rounded;
      longint raw;
      phase = 32'(64'(now) * PHASE_PER_MS + 64'(id) * PHASE_PER_ID);
      turn  = (64'(phase) * SINE_ENTRIES) >> 32;
      raw   = MID_Q16 + SWING * longint'(sine_q16[turn % SINE_ENTRIES]);
      if (raw < 0) raw = 0;
      rounded = ($unsigned(raw) + 64'd32768) >> 16;
      if (rounded > POS_MAX) rounded = POS_MAX;
      return 26'(rounded << 16);
    endfunction

    // bring one servo up to the given time stamp
    function void advance(int idx, logic [31:0] now);
      logic [31:0] gap;
      longint unsigned elapsed, rate, step, target, pos;
      if (!slewing[idx]) begin
        position_q16[idx] = idle_target(idx + 1, now);
      end else begin
        gap     = now - last_ms[idx];
        elapsed = (now >= last_ms[idx]) ? 64'(gap) : 64'd0;
        rate    = (speed[idx] == 16'd0) ? RATE_MAX : 64'(speed[idx]) * RATE_PER_SPEED;
        if (rate > RATE_MAX) rate = RATE_MAX;
        step = (elapsed >= STEP_SAT_ELAPSED) ? POS_MAX_Q16 : (rate * elapsed) >> 16;
        if (step > POS_MAX_Q16) step = POS_MAX_Q16;
        target = 64'(goal[idx]) << 16;
        pos    = 64'(position_q16[idx]);
        if (target > pos) pos = (target - pos > step) ? pos + step : target;
        else pos = (pos - target > step) ? pos - step : target;
        position_q16[idx] = 26'(pos);
      end
      last_ms[idx] = now;
    endfunction

    function void note_instruction(in_t item);
      int idx;
      out_t reply;
      longint unsigned rounded;
      if (item.motor_id < 1 || item.motor_id > SERVOS) return;
      served++;
      idx                = item.motor_id - 1;
      reply.reply_id     = item.motor_id[2:0];
      reply.has_position = 1'b0;
      reply.position     = '0;
      case (op_t'(item.command))
        OP_GOAL: begin
          advance(idx, item.now_ms);
          goal[idx]    = (item.value > POS_MAX) ? 10'(POS_MAX) : item.value[9:0];
          slewing[idx] = 1'b1;
          return;
        end
        OP_READ: begin
          if (item.reg_address != ADDR_PRESENT_POS || item.read_length != POS_READ_LEN)
            return;
          advance(idx, item.now_ms);
          rounded = (64'(position_q16[idx]) + 64'd32768) >> 16;
          if (rounded > POS_MAX) rounded = POS_MAX;
          reply.has_position = 1'b1;
          reply.position     = rounded[9:0];
        end
        OP_WRITE: begin
          if (item.reg_address != ADDR_MOVING_SPEED) return;
          speed[idx] = item.value;
        end
        OP_PING: ;
      endcase
      replies_due.push_back(reply);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("[%0t] MISMATCH %s", $time, what);
    endtask

    task check_reply(out_t got);
      out_t want;
      replies_seen++;
      if (replies_due.size() == 0) begin
        report_mismatch($sformatf("reply with none pending: id %0d has_pos %0b pos %0d",
                                  got.reply_id, got.has_position, got.position));
        return;
      end
      want = replies_due.pop_front();
      if (got.reply_id !== want.reply_id || got.has_position !== want.has_position ||
          got.position !== want.position)
        report_mismatch($sformatf("id %0d/%0d has_pos %0b/%0b pos %0d/%0d (got/want)",
                                  got.reply_id, want.reply_id, got.has_position,
                                  want.has_position, got.position, want.position));
      else if (want.has_position) position_replies++;
    endtask

    task flush_leftovers();
      out_t want;
      while (replies_due.size() != 0) begin
        want = replies_due.pop_front();
        report_mismatch($sformatf("reply never seen: id %0d has_pos %0b pos %0d",
                                  want.reply_id, want.has_position, want.position));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic out_valid;
  in_t  in_data;
  out_t out_data;

  servo_reply_board replies;
  int               cycle_count = 0;
  int               burst_left  = 0;
  int               issued      = 0;
  logic [31:0]      clock_ms;

  servo_bank_slew_emulator DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d replies pending", cycle_count,
               replies.replies_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // results cannot be held off: sample every strobe
  always @(posedge clk) begin
    if (rst_n && out_valid) replies.check_reply(out_data);
  end

  function automatic in_t instr(op_t cmd, logic [7:0] id, logic [7:0] addr,
                                logic [7:0] len, logic [15:0] val, logic [31:0] stamp);
    in_t item;
    item.command     = cmd;
    item.motor_id    = id;
    item.reg_address = addr;
    item.read_length = len;
    item.value       = val;
    item.now_ms      = stamp;
    return item;
  endfunction

  // mostly small forward steps; sometimes long gaps, backward steps or any stamp
  function automatic logic [31:0] next_stamp(logic [31:0] t);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return t + $urandom_range(0, 20);
    if (pick < 85) return t + $urandom_range(21, 3000);
    if (pick < 90) return t + $urandom_range(32'h10_0000, 32'h200_0000);
    if (pick < 95) return t - $urandom_range(1, 1000);
    return $urandom;
  endfunction

  function automatic in_t random_instruction(logic [31:0] stamp);
    in_t item;
    int unsigned pick;
    item.command     = 2'($urandom);
    item.motor_id    = 8'($urandom);
    item.reg_address = 8'($urandom);
    item.read_length = 8'($urandom);
    item.value       = 16'($urandom);
    item.now_ms      = stamp;
    if ($urandom_range(0, 99) < 15) return item;
    item.motor_id = 8'($urandom_range(1, SERVOS));
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      item.command = OP_GOAL;
      if ($urandom_range(0, 4) != 0) item.value = 16'($urandom_range(0, POS_MAX));
    end else if (pick < 65) begin
      item.command = OP_READ;
      if ($urandom_range(0, 19) != 0) begin
        item.reg_address = ADDR_PRESENT_POS;
        item.read_length = POS_READ_LEN;
      end
    end else if (pick < 80) begin
      item.command = OP_WRITE;
      if ($urandom_range(0, 19) != 0) item.reg_address = ADDR_MOVING_SPEED;
      pick = $urandom_range(0, 9);
      if (pick < 6) item.value = 16'($urandom_range(1, 400));
      else if (pick < 8) item.value = 16'd0;
    end else begin
      item.command = OP_PING;
    end
    return item;
  endfunction

  // hold start high until the block takes the transfer
  task automatic send(in_t item);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        start   <= 1'b0;
        in_data <= in_t'(74'({$urandom, $urandom, $urandom}));
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                              : $urandom_range(1, 20);
    end
    burst_left--;
    in_data <= item;
    start   <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    replies.note_instruction(item);
    issued++;
  endtask

  initial begin
    replies = new();
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send(instr(OP_PING, 8'd1, 8'd0, 8'd0, 16'd0, 32'd0));
    send(instr(OP_READ, 8'd1, ADDR_PRESENT_POS, POS_READ_LEN, 16'd0, 32'd0));
    send(instr(OP_READ, 8'd6, ADDR_PRESENT_POS, POS_READ_LEN, 16'd0, 32'd100));
    // ids outside the bank
    send(instr(OP_PING, 8'd0, 8'd0, 8'd0, 16'd0, 32'd100));
    send(instr(OP_READ, 8'd7, ADDR_PRESENT_POS, POS_READ_LEN, 16'd0, 32'd100));
    send(instr(OP_GOAL, 8'd255, 8'd0, 8'd0, 16'd500, 32'd100));
    // reads and writes of other control table entries
    send(instr(OP_READ, 8'd2, ADDR_PRESENT_POS - 8'd1, POS_READ_LEN, 16'd0, 32'd120));
    send(instr(OP_READ, 8'd2, ADDR_PRESENT_POS, 8'd1, 16'd0, 32'd120));
    send(instr(OP_READ, 8'd2, ADDR_PRESENT_POS, 8'd255, 16'd0, 32'd120));
    send(instr(OP_WRITE, 8'd3, ADDR_MOVING_SPEED + 8'd1, 8'd0, 16'd200, 32'd150));
    // speed zero runs at the top rate
    send(instr(OP_WRITE, 8'd3, ADDR_MOVING_SPEED, 8'd0, 16'd0, 32'd150));
    send(instr(OP_GOAL, 8'd3, 8'd0, 8'd0, 16'd1023, 32'd200));
    send(instr(OP_READ, 8'd3, ADDR_PRESENT_POS, POS_READ_LEN, 16'd0, 32'd210));
    send(instr(OP_READ, 8'd3, ADDR_PRESENT_POS, POS_READ_LEN, 16'd0, 32'd2000));
    // oversized speed and goal
    send(instr(OP_WRITE, 8'd4, ADDR_MOVING_SPEED, 8'd0, 16'hFFFF, 32'd300));
    send(instr(OP_GOAL, 8'd4, 8'd0, 8'd0, 16'hFFFF, 32'd300));
    send(instr(OP_READ, 8'd4, ADDR_PRESENT_POS, POS_READ_LEN, 16'd0, 32'd301));
    // time going back, then a gap long enough to saturate the step
    send(instr(OP_GOAL, 8'd5, 8'd0, 8'd0, 16'd0, 32'd400));
    send(instr(OP_READ, 8'd5, ADDR_PRESENT_POS, POS_READ_LEN, 16'd0, 32'd350));
    send(instr(OP_READ, 8'd5, ADDR_PRESENT_POS, POS_READ_LEN, 16'd0, 32'd400 + 32'h10_0000));
    // slowest nonzero speed
    send(instr(OP_WRITE, 8'd2, ADDR_MOVING_SPEED, 8'd0, 16'd1, 32'd500));
    send(instr(OP_GOAL, 8'd2, 8'd0, 8'd0, 16'd800, 32'd500));
    send(instr(OP_READ, 8'd2, ADDR_PRESENT_POS, POS_READ_LEN, 16'd0, 32'd900));
    send(instr(OP_READ, 8'd1, ADDR_PRESENT_POS, POS_READ_LEN, 16'd0, 32'hFFFF_FFFF));
    send(instr(OP_PING, 8'd6, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF));

    clock_ms = 32'd1000;
    while (issued < ITEM_TARGET) begin
      clock_ms = next_stamp(clock_ms);
      send(random_instruction(clock_ms));
    end

    start <= 1'b0;
    while (replies.replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    replies.flush_leftovers();

    $display("Sent %0d instructions, %0d to served ids; checked %0d replies, %0d with position.",
             issued, replies.served, replies.replies_seen, replies.position_replies);
    $display("Mix: idle sweep, slews at several speeds, clamped goals, backward time, long gaps.");
    if (replies.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", replies.mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
